FILE: hdl/qwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qwd_pkg;

  // tensor formats held in the format register
  typedef enum logic [1:0] {
    FMT_F32  = 2'd0,
    FMT_F16  = 2'd1,
    FMT_Q8_0 = 2'd2,
    FMT_Q4_K = 2'd3
  } fmt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCF,
    ST_MNF,
    ST_MUL,
    ST_ALIGN,
    ST_ROUND,
    ST_EMIT,
    ST_FINISH
  } state_t;

  // what the shared multiplier computes this cycle
  typedef enum logic [1:0] {
    MUL_SCF  = 2'd0,
    MUL_MNF  = 2'd1,
    MUL_PROD = 2'd2,
    MUL_NONE = 2'd3
  } mul_op_t;

  // where an output weight comes from
  typedef enum logic [1:0] {
    SRC_F32  = 2'd0,
    SRC_HALF = 2'd1,
    SRC_PROD = 2'd2,
    SRC_SUM  = 2'd3
  } src_t;

  typedef struct packed {
    logic    capture;
    logic    store;
    logic    e_clr;
    logic    e_inc;
    mul_op_t mul_op;
    logic    align_en;
    logic    round_en;
    logic    out_load;
    src_t    out_src;
    logic    pos_update;
  } cmd_t;

  typedef struct packed {
    logic is_header;
    logic res_last;
    logic to_high;
    logic out_free;
  } status_t;

  localparam int unsigned PosW = 7;
  localparam logic [PosW-1:0] Q8LastPos = 7'd16;
  localparam logic [PosW-1:0] Q4LastPos = 7'd71;
  localparam logic [PosW-1:0] Q4NibStart = 7'd8;
  localparam logic [5:0] Q4LastElem = 6'd33;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

endpackage
`default_nettype wire

FILE: hdl/qwd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module qwd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire qwd_pkg::fmt_t   fmt,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire qwd_pkg::status_t status,
  output qwd_pkg::cmd_t        cmd
);

  qwd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    cmd            = '0;
    cmd.mul_op     = qwd_pkg::MUL_NONE;
    cmd.out_src    = qwd_pkg::SRC_F32;
    unique case (state)
      qwd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = qwd_pkg::ST_DECODE;
        end
      end
      qwd_pkg::ST_DECODE: begin
        cmd.store = 1'b1;
        cmd.e_clr = 1'b1;
        if (status.is_header) begin
          state_next = qwd_pkg::ST_FINISH;
        end else begin
          unique case (fmt)
            qwd_pkg::FMT_F32, qwd_pkg::FMT_F16: state_next = qwd_pkg::ST_EMIT;
            qwd_pkg::FMT_Q8_0: state_next = qwd_pkg::ST_MUL;
            qwd_pkg::FMT_Q4_K: state_next = qwd_pkg::ST_SCF;
          endcase
        end
      end
      qwd_pkg::ST_SCF: begin
        cmd.mul_op = qwd_pkg::MUL_SCF;
        state_next = qwd_pkg::ST_MNF;
      end
      qwd_pkg::ST_MNF: begin
        cmd.mul_op = qwd_pkg::MUL_MNF;
        state_next = qwd_pkg::ST_MUL;
      end
      qwd_pkg::ST_MUL: begin
        cmd.mul_op = qwd_pkg::MUL_PROD;
        state_next = (fmt == qwd_pkg::FMT_Q8_0) ? qwd_pkg::ST_EMIT : qwd_pkg::ST_ALIGN;
      end
      qwd_pkg::ST_ALIGN: begin
        cmd.align_en = 1'b1;
        state_next   = qwd_pkg::ST_ROUND;
      end
      qwd_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        state_next   = qwd_pkg::ST_EMIT;
      end
      qwd_pkg::ST_EMIT: begin
        unique case (fmt)
          qwd_pkg::FMT_F32:  cmd.out_src = qwd_pkg::SRC_F32;
          qwd_pkg::FMT_F16:  cmd.out_src = qwd_pkg::SRC_HALF;
          qwd_pkg::FMT_Q8_0: cmd.out_src = qwd_pkg::SRC_PROD;
          qwd_pkg::FMT_Q4_K: cmd.out_src = qwd_pkg::SRC_SUM;
        endcase
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.res_last) begin
            state_next = qwd_pkg::ST_FINISH;
          end else begin
            cmd.e_inc  = 1'b1;
            state_next = status.to_high ? qwd_pkg::ST_SCF : qwd_pkg::ST_MUL;
          end
        end
      end
      qwd_pkg::ST_FINISH: begin
        cmd.pos_update = 1'b1;
        state_next     = qwd_pkg::ST_IDLE;
      end
      default: state_next = qwd_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/qwd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module qwd_dpath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire qwd_pkg::fmt_t    fmt,
  input  wire logic             pos_clr,
  input  wire qwd_pkg::cmd_t    cmd,
  input  wire logic [15:0]      s_tdata,
  input  wire logic             s_tlast,
  input  wire logic             m_tready,
  output qwd_pkg::status_t      status,
  output logic                  m_tvalid,
  output logic [31:0]           m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  // half to single, subnormals normalized
  function automatic logic [31:0] h2s(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  mt;
    logic [3:0]  hi;
    logic [3:0]  sh;
    logic [19:0] shifted;
    logic [31:0] r;
    ex = h[14:10];
    mt = h[9:0];
    hi = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mt[i]) hi = 4'(i);
    end
    sh = 4'd10 - hi;
    shifted = {10'b0, mt} << sh;
    if (ex == 5'd0) begin
      if (mt == 10'd0) r = {h[15], 31'b0};
      else r = {h[15], 8'(8'd113 - {4'b0, sh}), shifted[9:0], 13'b0};
    end else if (ex == 5'h1F) begin
      r = {h[15], 8'hFF, mt, 13'b0};
    end else begin
      r = {h[15], 8'({3'b0, ex} + 8'd112), mt, 13'b0};
    end
    return r;
  endfunction

  // small magnitude to single, exact
  function automatic logic [31:0] i2f(input logic sgn, input logic [7:0] mag);
    logic [2:0]  hi;
    logic [22:0] sh;
    hi = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) hi = 3'(i);
    end
    sh = {15'b0, mag} << (5'd23 - {2'b0, hi});
    if (mag == 8'd0) return 32'd0;
    return {sgn, 8'(8'd127 + {5'b0, hi}), sh};
  endfunction

  // single multiply, nearest even; operands normal, zero, inf or nan
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        s, na, nb, ia, ib, za, zb, g, st, up;
    logic [47:0] p;
    logic [9:0]  e;
    logic [22:0] m;
    logic [24:0] mm;
    logic [31:0] r;
    s  = a[31] ^ b[31];
    na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    za = (a[30:23] == 8'h00);
    zb = (b[30:23] == 8'h00);
    p  = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    e  = {2'b0, a[30:23]} + {2'b0, b[30:23]} - 10'd127;
    if (p[47]) begin
      m  = p[46:24];
      g  = p[23];
      st = |p[22:0];
      e  = e + 10'd1;
    end else begin
      m  = p[45:23];
      g  = p[22];
      st = |p[21:0];
    end
    up = g & (st | m[0]);
    mm = {2'b01, m} + {24'b0, up};
    if (mm[24]) e = e + 10'd1;
    r = {s, e[7:0], mm[22:0]};
    if (na || nb || (ia && zb) || (ib && za)) r = qwd_pkg::CanonNan;
    else if (ia || ib) r = {s, 8'hFF, 23'b0};
    else if (za || zb) r = {s, 31'b0};
    return r;
  endfunction

  logic [15:0]           raw;
  logic                  end_r;
  logic [qwd_pkg::PosW-1:0] pos;
  logic [15:0]           pend;
  logic [31:0]           dscale, dmin;
  logic [7:0]            packed_b [12];
  logic [3:0]            hn [32];
  logic [5:0]            e;
  logic [31:0]           scf, mnf, prod, sumr;

  logic [qwd_pkg::PosW-1:0] pv, pos_next;
  logic [3:0]            ci;
  logic [1:0]            cc;
  logic [2:0]            j;
  logic [5:0]            sc, mn;
  logic [3:0]            nib;
  logic [4:0]            k;
  logic [7:0]            qb, qmag;
  logic [31:0]           opa, opb, fm;

  assign pv = pos - qwd_pkg::Q4NibStart;
  assign ci = pv[3:0];
  assign cc = pv[5:4];
  assign j  = {cc, (e >= 6'd2)};
  assign k  = 5'(e - 6'd2);

  always_comb begin
    if (!j[2]) begin
      sc = packed_b[{2'b0, j[1:0]}][5:0];
      mn = packed_b[{2'b01, j[1:0]}][5:0];
    end else begin
      sc = {packed_b[{2'b0, j[1:0]}][7:6], packed_b[{2'b10, j[1:0]}][3:0]};
      mn = {packed_b[{2'b01, j[1:0]}][7:6], packed_b[{2'b10, j[1:0]}][7:4]};
    end
  end

  always_comb begin
    priority case (e)
      6'd0:    nib = raw[3:0];
      6'd1:    nib = raw[11:8];
      default: nib = hn[k];
    endcase
    qb   = e[0] ? raw[15:8] : raw[7:0];
    qmag = qb[7] ? 8'(-qb) : qb;
  end

  always_comb begin
    unique case (cmd.mul_op)
      qwd_pkg::MUL_SCF: begin
        opa = dscale;
        opb = i2f(1'b0, {2'b0, sc});
      end
      qwd_pkg::MUL_MNF: begin
        opa = dmin;
        opb = i2f(1'b0, {2'b0, mn});
      end
      default: begin
        if (fmt == qwd_pkg::FMT_Q8_0) begin
          opa = dscale;
          opb = i2f(qb[7], qmag);
        end else begin
          opa = scf;
          opb = i2f(1'b0, {4'b0, nib});
        end
      end
    endcase
    fm = fmul(opa, opb);
  end

  // prod - mnf, first stage: order and align
  logic [31:0] xa, xb, big, sml;
  logic        spec_a, eff_sub, zs_a;
  logic [31:0] spec_v_a;
  logic [7:0]  dexp;
  logic [26:0] yfull, yshift, xm;
  logic        lost;
  logic [27:0] sum_a;

  always_comb begin
    xa = prod;
    xb = {~mnf[31], mnf[30:0]};
    spec_a   = 1'b0;
    spec_v_a = qwd_pkg::CanonNan;
    if (((xa[30:23] == 8'hFF) && (xa[22:0] != 23'd0)) ||
        ((xb[30:23] == 8'hFF) && (xb[22:0] != 23'd0))) begin
      spec_a = 1'b1;
    end else if ((xa[30:23] == 8'hFF) && (xb[30:23] == 8'hFF)) begin
      spec_a   = 1'b1;
      spec_v_a = (xa[31] == xb[31]) ? xa : qwd_pkg::CanonNan;
    end else if (xa[30:23] == 8'hFF) begin
      spec_a   = 1'b1;
      spec_v_a = xa;
    end else if (xb[30:23] == 8'hFF) begin
      spec_a   = 1'b1;
      spec_v_a = xb;
    end
    zs_a = xa[31] & xb[31];
    if (xa[30:0] >= xb[30:0]) begin
      big = xa;
      sml = xb;
    end else begin
      big = xb;
      sml = xa;
    end
    eff_sub = xa[31] ^ xb[31];
    dexp  = big[30:23] - sml[30:23];
    xm    = {(big[30:23] != 8'd0), big[22:0], 3'b0};
    yfull = {(sml[30:23] != 8'd0), sml[22:0], 3'b0};
    lost  = 1'b0;
    if (dexp >= 8'd27) begin
      yshift = {26'b0, |yfull};
    end else begin
      yshift = yfull >> dexp[4:0];
      lost   = (yshift << dexp[4:0]) != yfull;
      yshift[0] = yshift[0] | lost;
    end
    sum_a = eff_sub ? ({1'b0, xm} - {1'b0, yshift}) : ({1'b0, xm} + {1'b0, yshift});
  end

  logic        spec_r, sgn_r, zs_r;
  logic [31:0] spec_v_r;
  logic [7:0]  exp_r;
  logic [27:0] sum_r;

  // second stage: normalize and round
  logic [4:0]  lz;
  logic [26:0] t;
  logic [8:0]  eb;
  logic        up;
  logic [24:0] mm;
  logic [31:0] rnd;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (sum_r[i]) lz = 5'(26 - i);
    end
    if (sum_r[27]) begin
      t  = {sum_r[27:2], sum_r[1] | sum_r[0]};
      eb = {1'b0, exp_r} + 9'd1;
    end else begin
      t  = sum_r[26:0] << lz;
      eb = {1'b0, exp_r} - {4'b0, lz};
    end
    up = t[2] & (t[1] | t[0] | t[3]);
    mm = {1'b0, t[26:3]} + {24'b0, up};
    if (mm[24]) eb = eb + 9'd1;
    rnd = {sgn_r, eb[7:0], mm[22:0]};
    if (spec_r) rnd = spec_v_r;
    else if (sum_r == 28'd0) rnd = {zs_r, 31'b0};
  end

  // position after this item
  always_comb begin
    unique case (fmt)
      qwd_pkg::FMT_F32:  pos_next = (pos == '0) ? 7'd1 : 7'd0;
      qwd_pkg::FMT_F16:  pos_next = '0;
      qwd_pkg::FMT_Q8_0: pos_next = (pos == '0) ? 7'd1 :
                                    (pos >= qwd_pkg::Q8LastPos) ? 7'd0 : pos + 7'd1;
      qwd_pkg::FMT_Q4_K: pos_next = (pos >= qwd_pkg::Q4LastPos) ? 7'd0 : pos + 7'd1;
    endcase
    if (end_r) pos_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      e        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pos_clr) pos <= '0;
      else if (cmd.pos_update) pos <= pos_next;
      if (cmd.e_clr) e <= '0;
      else if (cmd.e_inc) e <= e + 6'd1;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw   <= s_tdata;
      end_r <= s_tlast;
    end
    if (cmd.store) begin
      unique case (fmt)
        qwd_pkg::FMT_F32: if (pos == '0) pend <= raw;
        qwd_pkg::FMT_F16: ;
        qwd_pkg::FMT_Q8_0: if (pos == '0) dscale <= h2s(raw);
        qwd_pkg::FMT_Q4_K: begin
          if (pos == 7'd0) dscale <= h2s(raw);
          else if (pos == 7'd1) dmin <= h2s(raw);
          else if (pos < qwd_pkg::Q4NibStart) begin
            packed_b[{pos[2:0] - 3'd2, 1'b0}] <= raw[7:0];
            packed_b[{pos[2:0] - 3'd2, 1'b1}] <= raw[15:8];
          end else begin
            hn[{ci, 1'b0}] <= raw[7:4];
            hn[{ci, 1'b1}] <= raw[15:12];
          end
        end
      endcase
    end
    unique case (cmd.mul_op)
      qwd_pkg::MUL_SCF:  scf <= fm;
      qwd_pkg::MUL_MNF:  mnf <= fm;
      qwd_pkg::MUL_PROD: prod <= fm;
      qwd_pkg::MUL_NONE: ;
    endcase
    if (cmd.align_en) begin
      spec_r   <= spec_a;
      spec_v_r <= spec_v_a;
      sgn_r    <= big[31];
      zs_r     <= zs_a;
      exp_r    <= big[30:23];
      sum_r    <= sum_a;
    end
    if (cmd.round_en) sumr <= rnd;
    if (cmd.out_load) begin
      unique case (cmd.out_src)
        qwd_pkg::SRC_F32:  m_tdata <= {raw, pend};
        qwd_pkg::SRC_HALF: m_tdata <= h2s(raw);
        qwd_pkg::SRC_PROD: m_tdata <= prod;
        qwd_pkg::SRC_SUM:  m_tdata <= sumr;
      endcase
      m_tlast <= status.res_last;
      m_tuser <= ((fmt == qwd_pkg::FMT_Q8_0) && (e == 6'd1) && (pos >= qwd_pkg::Q8LastPos)) ||
                 ((fmt == qwd_pkg::FMT_Q4_K) && (e == qwd_pkg::Q4LastElem) &&
                  (pos == qwd_pkg::Q4LastPos));
    end
  end

  always_comb begin
    status.out_free  = !m_tvalid || m_tready;
    status.is_header = ((fmt == qwd_pkg::FMT_F32) && (pos == '0)) ||
                       ((fmt == qwd_pkg::FMT_Q8_0) && (pos == '0)) ||
                       ((fmt == qwd_pkg::FMT_Q4_K) && (pos < qwd_pkg::Q4NibStart));
    status.to_high   = (fmt == qwd_pkg::FMT_Q4_K) && (e == 6'd1) && (ci == 4'd15);
    unique case (fmt)
      qwd_pkg::FMT_F32, qwd_pkg::FMT_F16: status.res_last = 1'b1;
      qwd_pkg::FMT_Q8_0: status.res_last = (e == 6'd1);
      qwd_pkg::FMT_Q4_K: status.res_last = (ci == 4'd15) ? (e == qwd_pkg::Q4LastElem)
                                                          : (e == 6'd1);
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/quantized_weight_dequantizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Dequantizes a tensor's raw data, fed as little-endian halfwords, into FP32 weights in
// element order. The format register (byte address 0) picks fp32 copy, fp16, q8_0 or
// q4_k; writing it restarts block parsing, as does tensor_end (s_tlast) after its item.
// One input item is handled at a time by a controller and a datapath with a single shared
// fp32 multiplier and a two-stage fp32 subtractor. An item is captured and decoded;
// fp32 data and fp16 then give one output, headers none, q8_0 data a multiply and
// output per weight, q4_k data two scale products, then per weight a multiply, align,
// round and output, with two more scale products and the 32 high-nibble weights after
// the low ones in the last item of each 32-byte chunk. A result waits in an output
// register for m_tready, so a stalled master side only holds the current item.
module quantized_weight_dequantizer (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // raw_half
  input  wire logic        s_tlast,   // tensor_end
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // weight_bits
  output logic             m_tlast,   // last_of_run
  output logic             m_tuser,   // end_of_block
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  qwd_pkg::fmt_t    fmt;
  qwd_pkg::cmd_t    cmd;
  qwd_pkg::status_t status;
  logic             cfg_wr;

  // single register, so every address in range selects it
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] <= 2'd3);
  assign pready = 1'b1;
  assign prdata = {30'b0, fmt};

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= qwd_pkg::FMT_F32;
    end else if (cfg_wr) begin
      fmt <= qwd_pkg::fmt_t'(pwdata[1:0]);
    end
  end

  qwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fmt      (fmt),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  qwd_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .fmt      (fmt),
    .pos_clr  (cfg_wr),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire
